/* rtl/chs_pkg.sv */
// ---------------------------------------------------------------------------
// chs_pkg
// shared types and constants of the cardinal hermite spline table
// ---------------------------------------------------------------------------
package chs_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int KIND_W  = 4;
  localparam int IDX_W   = 8;
  localparam int DAT_W   = 32;
  localparam int PT_W    = 24;
  localparam int TEN_W   = 19;
  localparam int TOT_W   = 9;
  localparam int ERR_W   = 2;
  localparam int S_DATA_W = 232;
  localparam int M_DATA_W = 144;

  typedef enum logic [KIND_W-1:0] {
    OP_APPEND    = 4'd0,
    OP_INSERT    = 4'd1,
    OP_REMOVE    = 4'd2,
    OP_CLEAR     = 4'd3,
    OP_SET_POINT = 4'd4,
    OP_SET_POS   = 4'd5,
    OP_SET_VEL   = 4'd6,
    OP_CARDINAL  = 4'd7,
    OP_READ      = 4'd8,
    OP_EVAL_CUM  = 4'd9,
    OP_EVAL_NORM = 4'd10,
    OP_NONE      = 4'd15
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] px;
    logic signed [DAT_W-1:0] py;
    logic signed [DAT_W-1:0] vx;
    logic signed [DAT_W-1:0] vy;
    logic signed [DAT_W-1:0] evx;
    logic signed [DAT_W-1:0] evy;
    logic                    hv;
    logic [PT_W-1:0]         pt;
  } item_t;

endpackage

/* rtl/chs_front.sv */
// ---------------------------------------------------------------------------
// chs_front
// accepts input items, decodes the kind and queues them for the engine
// ---------------------------------------------------------------------------
module chs_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [chs_pkg::S_DATA_W-1:0]         s_tdata_i,
  input  logic [chs_pkg::KIND_W-1:0]           s_tuser_i,
  output logic                                 item_valid_o,
  output chs_pkg::item_t                       item_o,
  input  logic                                 item_pop_i
);

  chs_pkg::item_t q_mem [2];
  chs_pkg::item_t in_item;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  always_comb begin
    case (s_tuser_i)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: begin
        in_item.op = chs_pkg::op_e'(s_tuser_i);
      end
      default: begin
        in_item.op = chs_pkg::OP_NONE;
      end
    endcase
    in_item.idx = s_tdata_i[7:0];
    in_item.px  = s_tdata_i[39:8];
    in_item.py  = s_tdata_i[71:40];
    in_item.vx  = s_tdata_i[103:72];
    in_item.vy  = s_tdata_i[135:104];
    in_item.evx = s_tdata_i[167:136];
    in_item.evy = s_tdata_i[199:168];
    in_item.hv  = s_tdata_i[200];
    in_item.pt  = s_tdata_i[224:201];
  end

  assign s_tready_o   = (cnt_q != 2'd2);
  assign push         = s_tvalid_i & s_tready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_pop_i & item_valid_o;
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

endmodule

/* rtl/chs_back.sv */
// ---------------------------------------------------------------------------
// chs_back
// point table memories, operation sequencer, arithmetic and result register
// ---------------------------------------------------------------------------
module chs_back #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = chs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 item_valid_i,
  input  chs_pkg::item_t                       item_i,
  output logic                                 item_pop_o,
  input  logic                                 tension_we_i,
  input  logic [chs_pkg::TEN_W-1:0]            tension_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [chs_pkg::DAT_W-1:0]            out_x_o,
  output logic [chs_pkg::DAT_W-1:0]            out_y_o,
  output logic [chs_pkg::DAT_W-1:0]            out_vx_o,
  output logic [chs_pkg::DAT_W-1:0]            out_vy_o,
  output logic [chs_pkg::TOT_W-1:0]            total_o,
  output logic [chs_pkg::ERR_W-1:0]            err_o
);

  localparam int AW   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int XW   = (CW > chs_pkg::IDX_W) ? CW : chs_pkg::IDX_W;
  localparam int KW   = ((FRAC_BITS + 2 > chs_pkg::TEN_W) ? FRAC_BITS + 2 : chs_pkg::TEN_W) + 1;
  localparam int DW   = chs_pkg::DAT_W + 1;
  localparam int PCW  = DW + KW;
  localparam int HW   = FRAC_BITS + 3;
  localparam int PHW  = HW + chs_pkg::DAT_W;
  localparam int SHW  = PHW + 2;
  localparam int SW   = chs_pkg::PT_W + CW;
  localparam int GW   = SW - FRAC_BITS;
  localparam int EW   = 2 * chs_pkg::DAT_W;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_OUT  = 5'd1;
  localparam logic [4:0] ST_INS  = 5'd2;
  localparam logic [4:0] ST_INSW = 5'd3;
  localparam logic [4:0] ST_REM  = 5'd4;
  localparam logic [4:0] ST_REMW = 5'd5;
  localparam logic [4:0] ST_CE   = 5'd6;
  localparam logic [4:0] ST_CA   = 5'd7;
  localparam logic [4:0] ST_CB   = 5'd8;
  localparam logic [4:0] ST_CC   = 5'd9;
  localparam logic [4:0] ST_CD   = 5'd10;
  localparam logic [4:0] ST_RD   = 5'd11;
  localparam logic [4:0] ST_EV0  = 5'd12;
  localparam logic [4:0] ST_EV1  = 5'd13;
  localparam logic [4:0] ST_EV2  = 5'd14;
  localparam logic [4:0] ST_EV3  = 5'd15;
  localparam logic [4:0] ST_EV4  = 5'd16;
  localparam logic [4:0] ST_EV5  = 5'd17;
  localparam logic [4:0] ST_EV6  = 5'd18;

  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);
  localparam logic signed [KW-1:0] ONE_K = KW'(1) << FRAC_BITS;
  localparam logic signed [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
  localparam logic signed [PCW-1:0] RND_C = PCW'(1) << FRAC_BITS;
  localparam logic signed [SHW-1:0] RND_H = SHW'(1) << (FRAC_BITS - 1);

  // {y, x} per entry
  logic [EW-1:0] pos_mem [MAX_POINTS];
  logic [EW-1:0] vel_mem [MAX_POINTS];
  logic [EW-1:0] pos_rd_q, vel_rd_q;
  logic          pos_we, vel_we;
  logic [AW-1:0] pos_wa, vel_wa, pos_ra, vel_ra;
  logic [EW-1:0] pos_wd, vel_wd;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] j_q, j_d;
  logic          m_valid_q, m_valid_d;
  logic signed [chs_pkg::TEN_W-1:0] ten_q;

  chs_pkg::item_t it_q, it_d;
  logic [SW-1:0]        s_q, s_d;
  logic [FRAC_BITS-1:0] u_q, u_d, u2_q, u2_d, u3_q, u3_d;
  logic [EW-1:0]        prev_q, prev_d, p0_q, p0_d, v0_q, v0_d, p1_q, p1_d, v1_q, v1_d;
  logic signed [PCW-1:0] pcx_q, pcx_d, pcy_q, pcy_d;
  logic signed [HW-1:0]  h_q [4];
  logic signed [HW-1:0]  h_d [4];
  logic signed [PHW-1:0] pr_q [8];
  logic signed [PHW-1:0] pr_d [8];
  logic signed [SHW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [chs_pkg::DAT_W-1:0] rx_q, rx_d, ry_q, ry_d, rvx_q, rvx_d, rvy_q, rvy_d;
  chs_pkg::err_e        rerr_q, rerr_d;
  logic [chs_pkg::DAT_W-1:0] ox_q, ox_d, oy_q, oy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic [chs_pkg::TOT_W-1:0] ot_q, ot_d;
  logic [chs_pkg::ERR_W-1:0] oe_q, oe_d;

  logic [XW-1:0]   idx_x, it_idx_x, n_x;
  logic [GW-1:0]   seg;
  logic signed [KW-1:0] kk;
  logic signed [DW-1:0] dx, dy;
  logic signed [HW-1:0] u1e, u2e, u3e;
  logic signed [PCW-1:0] rcx, rcy;
  logic signed [SHW-1:0] rhx, rhy;
  logic [chs_pkg::DAT_W-1:0] satcx, satcy, sathx, sathy;
  logic [CW-1:0]   nm1;

  assign m_valid_o = m_valid_q;
  assign out_x_o   = ox_q;
  assign out_y_o   = oy_q;
  assign out_vx_o  = ovx_q;
  assign out_vy_o  = ovy_q;
  assign total_o   = ot_q;
  assign err_o     = oe_q;

  always_comb begin
    idx_x    = XW'(item_i.idx);
    it_idx_x = XW'(it_q.idx);
    n_x      = XW'(cnt_q);
    nm1      = (cnt_q != '0) ? cnt_q - CW'(1) : '0;
    seg      = s_q[SW-1:FRAC_BITS];
    kk       = ONE_K - {{(KW - chs_pkg::TEN_W){ten_q[chs_pkg::TEN_W-1]}}, ten_q};
    dx = $signed({pos_rd_q[31], pos_rd_q[31:0]}) - $signed({prev_q[31], prev_q[31:0]});
    dy = $signed({pos_rd_q[63], pos_rd_q[63:32]}) - $signed({prev_q[63], prev_q[63:32]});
    u1e = $signed({3'b000, u_q});
    u2e = $signed({3'b000, u2_q});
    u3e = $signed({3'b000, u3_q});
    rcx = (pcx_q + RND_C) >>> (FRAC_BITS + 1);
    rcy = (pcy_q + RND_C) >>> (FRAC_BITS + 1);
    rhx = (sx_q + RND_H) >>> FRAC_BITS;
    rhy = (sy_q + RND_H) >>> FRAC_BITS;
    if (&rcx[PCW-1:31] || ~|rcx[PCW-1:31]) begin
      satcx = rcx[31:0];
    end else begin
      satcx = rcx[PCW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    if (&rcy[PCW-1:31] || ~|rcy[PCW-1:31]) begin
      satcy = rcy[31:0];
    end else begin
      satcy = rcy[PCW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    if (&rhx[SHW-1:31] || ~|rhx[SHW-1:31]) begin
      sathx = rhx[31:0];
    end else begin
      sathx = rhx[SHW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    if (&rhy[SHW-1:31] || ~|rhy[SHW-1:31]) begin
      sathy = rhy[31:0];
    end else begin
      sathy = rhy[SHW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    it_d    = it_q;
    s_d     = s_q;
    u_d     = u_q;
    u2_d    = u2_q;
    u3_d    = u3_q;
    prev_d  = prev_q;
    p0_d    = p0_q;
    v0_d    = v0_q;
    p1_d    = p1_q;
    v1_d    = v1_q;
    pcx_d   = pcx_q;
    pcy_d   = pcy_q;
    h_d     = h_q;
    pr_d    = pr_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rvx_d   = rvx_q;
    rvy_d   = rvy_q;
    rerr_d  = rerr_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    ovx_d   = ovx_q;
    ovy_d   = ovy_q;
    ot_d    = ot_q;
    oe_d    = oe_q;
    m_valid_d  = m_valid_q & ~m_ready_i;
    item_pop_o = 1'b0;
    pos_we = 1'b0;
    vel_we = 1'b0;
    pos_wa = j_q[AW-1:0];
    vel_wa = j_q[AW-1:0];
    pos_wd = pos_rd_q;
    vel_wd = vel_rd_q;
    pos_ra = j_q[AW-1:0];
    vel_ra = j_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          it_d   = item_i;
          rx_d   = '0;
          ry_d   = '0;
          rvx_d  = '0;
          rvy_d  = '0;
          rerr_d = chs_pkg::ERR_OK;
          state_d = ST_OUT;
          case (item_i.op)
            chs_pkg::OP_APPEND: begin
              if (cnt_q >= FULL_CNT) begin
                rerr_d = chs_pkg::ERR_FULL;
              end else begin
                pos_we = 1'b1;
                vel_we = 1'b1;
                pos_wa = cnt_q[AW-1:0];
                vel_wa = cnt_q[AW-1:0];
                pos_wd = {item_i.py, item_i.px};
                vel_wd = item_i.hv ? {item_i.vy, item_i.vx} : '0;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            chs_pkg::OP_INSERT: begin
              if (idx_x > n_x) begin
                rerr_d = chs_pkg::ERR_RANGE;
              end else if (cnt_q >= FULL_CNT) begin
                rerr_d = chs_pkg::ERR_FULL;
              end else begin
                j_d     = cnt_q;
                state_d = ST_INS;
              end
            end
            chs_pkg::OP_REMOVE: begin
              if (idx_x >= n_x) begin
                rerr_d = chs_pkg::ERR_RANGE;
              end else begin
                j_d     = idx_x[CW-1:0];
                state_d = ST_REM;
              end
            end
            chs_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            chs_pkg::OP_SET_POINT, chs_pkg::OP_SET_POS, chs_pkg::OP_SET_VEL: begin
              if (idx_x >= n_x) begin
                rerr_d = chs_pkg::ERR_RANGE;
              end else begin
                pos_we = (item_i.op != chs_pkg::OP_SET_VEL);
                vel_we = (item_i.op != chs_pkg::OP_SET_POS);
                pos_wa = idx_x[AW-1:0];
                vel_wa = idx_x[AW-1:0];
                pos_wd = {item_i.py, item_i.px};
                vel_wd = {item_i.vy, item_i.vx};
              end
            end
            chs_pkg::OP_CARDINAL: begin
              if (cnt_q > CW'(1)) begin
                vel_we  = 1'b1;
                vel_wa  = '0;
                vel_wd  = {item_i.vy, item_i.vx};
                state_d = ST_CE;
              end
            end
            chs_pkg::OP_READ: begin
              if (idx_x >= n_x) begin
                rerr_d = chs_pkg::ERR_RANGE;
              end else begin
                pos_ra  = idx_x[AW-1:0];
                vel_ra  = idx_x[AW-1:0];
                state_d = ST_RD;
              end
            end
            chs_pkg::OP_EVAL_CUM: begin
              s_d     = SW'(item_i.pt);
              state_d = ST_EV0;
            end
            chs_pkg::OP_EVAL_NORM: begin
              s_d     = SW'(item_i.pt * nm1);
              state_d = ST_EV0;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_INS: begin
        if (XW'(j_q) > it_idx_x) begin
          pos_ra  = j_q[AW-1:0] - AW'(1);
          vel_ra  = j_q[AW-1:0] - AW'(1);
          state_d = ST_INSW;
        end else begin
          pos_we  = 1'b1;
          vel_we  = 1'b1;
          pos_wd  = {it_q.py, it_q.px};
          vel_wd  = {it_q.vy, it_q.vx};
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_OUT;
        end
      end
      ST_INSW: begin
        pos_we  = 1'b1;
        vel_we  = 1'b1;
        j_d     = j_q - CW'(1);
        state_d = ST_INS;
      end
      ST_REM: begin
        if ((j_q + CW'(1)) < cnt_q) begin
          pos_ra  = j_q[AW-1:0] + AW'(1);
          vel_ra  = j_q[AW-1:0] + AW'(1);
          state_d = ST_REMW;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_OUT;
        end
      end
      ST_REMW: begin
        pos_we  = 1'b1;
        vel_we  = 1'b1;
        j_d     = j_q + CW'(1);
        state_d = ST_REM;
      end
      ST_CE: begin
        vel_we  = 1'b1;
        vel_wa  = nm1[AW-1:0];
        vel_wd  = {it_q.evy, it_q.evx};
        j_d     = CW'(1);
        state_d = ST_CA;
      end
      ST_CA: begin
        if ((j_q + CW'(1)) < cnt_q) begin
          pos_ra  = j_q[AW-1:0] - AW'(1);
          state_d = ST_CB;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_CB: begin
        prev_d  = pos_rd_q;
        pos_ra  = j_q[AW-1:0] + AW'(1);
        state_d = ST_CC;
      end
      ST_CC: begin
        pcx_d   = dx * kk;
        pcy_d   = dy * kk;
        state_d = ST_CD;
      end
      ST_CD: begin
        vel_we  = 1'b1;
        vel_wd  = {satcy, satcx};
        j_d     = j_q + CW'(1);
        state_d = ST_CA;
      end
      ST_RD: begin
        rx_d    = pos_rd_q[31:0];
        ry_d    = pos_rd_q[63:32];
        rvx_d   = vel_rd_q[31:0];
        rvy_d   = vel_rd_q[63:32];
        state_d = ST_OUT;
      end
      ST_EV0: begin
        if (cnt_q < CW'(2) || SW'(seg) >= SW'(nm1)) begin
          rerr_d  = chs_pkg::ERR_RANGE;
          state_d = ST_OUT;
        end else begin
          pos_ra  = seg[AW-1:0];
          vel_ra  = seg[AW-1:0];
          j_d     = seg[CW-1:0];
          u_d     = s_q[FRAC_BITS-1:0];
          state_d = ST_EV1;
        end
      end
      ST_EV1: begin
        p0_d    = pos_rd_q;
        v0_d    = vel_rd_q;
        pos_ra  = j_q[AW-1:0] + AW'(1);
        vel_ra  = j_q[AW-1:0] + AW'(1);
        u2_d    = FRAC_BITS'((2 * FRAC_BITS)'(u_q) * (2 * FRAC_BITS)'(u_q) >> FRAC_BITS);
        state_d = ST_EV2;
      end
      ST_EV2: begin
        p1_d    = pos_rd_q;
        v1_d    = vel_rd_q;
        u3_d    = FRAC_BITS'((2 * FRAC_BITS)'(u2_q) * (2 * FRAC_BITS)'(u_q) >> FRAC_BITS);
        state_d = ST_EV3;
      end
      ST_EV3: begin
        h_d[0]  = (u3e <<< 1) - (u2e + (u2e <<< 1)) + ONE_H;
        h_d[1]  = u3e - (u2e <<< 1) + u1e;
        h_d[2]  = (u2e + (u2e <<< 1)) - (u3e <<< 1);
        h_d[3]  = u3e - u2e;
        state_d = ST_EV4;
      end
      ST_EV4: begin
        pr_d[0] = h_q[0] * $signed(p0_q[31:0]);
        pr_d[1] = h_q[1] * $signed(v0_q[31:0]);
        pr_d[2] = h_q[2] * $signed(p1_q[31:0]);
        pr_d[3] = h_q[3] * $signed(v1_q[31:0]);
        pr_d[4] = h_q[0] * $signed(p0_q[63:32]);
        pr_d[5] = h_q[1] * $signed(v0_q[63:32]);
        pr_d[6] = h_q[2] * $signed(p1_q[63:32]);
        pr_d[7] = h_q[3] * $signed(v1_q[63:32]);
        state_d = ST_EV5;
      end
      ST_EV5: begin
        sx_d = SHW'(pr_q[0]) + SHW'(pr_q[1]) + SHW'(pr_q[2]) + SHW'(pr_q[3]);
        sy_d = SHW'(pr_q[4]) + SHW'(pr_q[5]) + SHW'(pr_q[6]) + SHW'(pr_q[7]);
        state_d = ST_EV6;
      end
      ST_EV6: begin
        rx_d    = sathx;
        ry_d    = sathy;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          m_valid_d = 1'b1;
          ox_d    = rx_q;
          oy_d    = ry_q;
          ovx_d   = rvx_q;
          ovy_d   = rvy_q;
          ot_d    = chs_pkg::TOT_W'(cnt_q);
          oe_d    = rerr_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      j_q       <= '0;
      m_valid_q <= 1'b0;
      ten_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      j_q       <= j_d;
      m_valid_q <= m_valid_d;
      if (tension_we_i) begin
        ten_q <= tension_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    s_q    <= s_d;
    u_q    <= u_d;
    u2_q   <= u2_d;
    u3_q   <= u3_d;
    prev_q <= prev_d;
    p0_q   <= p0_d;
    v0_q   <= v0_d;
    p1_q   <= p1_d;
    v1_q   <= v1_d;
    pcx_q  <= pcx_d;
    pcy_q  <= pcy_d;
    h_q    <= h_d;
    pr_q   <= pr_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    rvx_q  <= rvx_d;
    rvy_q  <= rvy_d;
    rerr_q <= rerr_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    ovx_q  <= ovx_d;
    ovy_q  <= ovy_d;
    ot_q   <= ot_d;
    oe_q   <= oe_d;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vel_we) begin
      vel_mem[vel_wa] <= vel_wd;
    end
    vel_rd_q <= vel_mem[vel_ra];
  end

endmodule

/* rtl/cardinal_hermite_spline_table.sv */
// ---------------------------------------------------------------------------
// cardinal_hermite_spline_table
// 2d control point table with cardinal velocities and hermite evaluation
// ---------------------------------------------------------------------------
// input items arrive on the s_axis group, kind in tuser, one result item per
// input item leaves on the m_axis group, error code in tuser.
// a two-entry queue holds decoded items while the engine works on one item.
// the engine runs one item at a time over simple dual-port position and velocity
// memories (one read, one write per cycle); insert and remove move the table
// entries one at a time, and cardinal computes the interior velocities one
// point at a time.
// tension is written through tension_we_i / tension_i; the user must write it only while idle (not enforced).
// reset empties the table (count zero) and zeroes tension; memory contents
// are not cleared and need no sweep.
// a stalled receiver holds the result register; the engine then finishes the
// next item and waits, and the queue keeps accepting up to two more items.
// ---------------------------------------------------------------------------
module cardinal_hermite_spline_table #(
  parameter int MAX_POINTS = chs_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = chs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tension_we_i,
  input  logic [chs_pkg::TEN_W-1:0]     tension_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // index, pos_x, pos_y, vel_x, vel_y, end_vel_x, end_vel_y, has_velocity, param_t
  input  logic [chs_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [chs_pkg::KIND_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_vx, out_vy, point_total
  output logic [chs_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // error
  output logic [chs_pkg::ERR_W-1:0]     m_axis_tuser
);

  logic                      item_valid;
  logic                      item_pop;
  chs_pkg::item_t            item;
  logic [chs_pkg::DAT_W-1:0] out_x, out_y, out_vx, out_vy;
  logic [chs_pkg::TOT_W-1:0] total;

  chs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  chs_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .tension_we_i (tension_we_i),
    .tension_i    (tension_i),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_vx_o     (out_vx),
    .out_vy_o     (out_vy),
    .total_o      (total),
    .err_o        (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, total, out_vy, out_vx, out_y, out_x};

endmodule

/* tb/sv/tb_cardinal_hermite_spline_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cardinal_hermite_spline_table
// self-checking bench for the 2d hermite spline point table: a directed
// table of operations, then random phases at several tension settings,
// each result compared by field to fixed values or a behavioral predictor
// ---------------------------------------------------------------------------
module tb_cardinal_hermite_spline_table;
  import chs_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int PHASE_ITEMS     = 270;

  typedef struct {
    logic signed [DAT_W-1:0] x;
    logic signed [DAT_W-1:0] y;
    logic signed [DAT_W-1:0] vx;
    logic signed [DAT_W-1:0] vy;
    logic [TOT_W-1:0]        total;
    err_e                    err;
  } result_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                tension_we_i;
  logic [TEN_W-1:0]    tension_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0]   s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ERR_W-1:0]    m_axis_tuser;

  cardinal_hermite_spline_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tension_we_i  (tension_we_i),
    .tension_i     (tension_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic signed [DAT_W-1:0] pos_x_mem [MAX_POINTS_DEF];
  logic signed [DAT_W-1:0] pos_y_mem [MAX_POINTS_DEF];
  logic signed [DAT_W-1:0] vel_x_mem [MAX_POINTS_DEF];
  logic signed [DAT_W-1:0] vel_y_mem [MAX_POINTS_DEF];
  int      point_cnt;
  longint  tension_q;

  result_t pending_results[$];
  int      mismatch_cnt;
  int      results_seen;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [DAT_W-1:0] clip_s32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [DAT_W-1:0] hermite_blend(longint p0, longint v0,
                                                            longint p1, longint v1,
                                                            longint u);
    longint u2, u3, h00, h10, h01, h11, sum;
    u2  = (u * u) >>> 16;
    u3  = (u2 * u) >>> 16;
    h00 = 2 * u3 - 3 * u2 + 65536;
    h10 = u3 - 2 * u2 + u;
    h01 = 3 * u2 - 2 * u3;
    h11 = u3 - u2;
    sum = h00 * p0 + h10 * v0 + h01 * p1 + h11 * v1;
    return clip_s32((sum + 32768) >>> 16);
  endfunction

  function automatic result_t spline_predict(item_t it);
    result_t r;
    int      n, i, ix;
    longint  k, s, seg, u, dx, dy;
    r.x = '0; r.y = '0; r.vx = '0; r.vy = '0; r.err = ERR_OK;
    n  = point_cnt;
    ix = it.idx;
    case (it.op)
      OP_APPEND: begin
        if (n >= MAX_POINTS_DEF) r.err = ERR_FULL;
        else begin
          pos_x_mem[n] = it.px;
          pos_y_mem[n] = it.py;
          vel_x_mem[n] = it.hv ? it.vx : '0;
          vel_y_mem[n] = it.hv ? it.vy : '0;
          point_cnt = n + 1;
        end
      end
      OP_INSERT: begin
        if (ix > n) r.err = ERR_RANGE;
        else if (n >= MAX_POINTS_DEF) r.err = ERR_FULL;
        else begin
          for (i = n; i > ix; i--) begin
            pos_x_mem[i] = pos_x_mem[i-1];
            pos_y_mem[i] = pos_y_mem[i-1];
            vel_x_mem[i] = vel_x_mem[i-1];
            vel_y_mem[i] = vel_y_mem[i-1];
          end
          pos_x_mem[ix] = it.px;
          pos_y_mem[ix] = it.py;
          vel_x_mem[ix] = it.vx;
          vel_y_mem[ix] = it.vy;
          point_cnt = n + 1;
        end
      end
      OP_REMOVE: begin
        if (ix >= n) r.err = ERR_RANGE;
        else begin
          for (i = ix; i < n - 1; i++) begin
            pos_x_mem[i] = pos_x_mem[i+1];
            pos_y_mem[i] = pos_y_mem[i+1];
            vel_x_mem[i] = vel_x_mem[i+1];
            vel_y_mem[i] = vel_y_mem[i+1];
          end
          point_cnt = n - 1;
        end
      end
      OP_CLEAR: point_cnt = 0;
      OP_SET_POINT, OP_SET_POS, OP_SET_VEL: begin
        if (ix >= n) r.err = ERR_RANGE;
        else begin
          if (it.op != OP_SET_VEL) begin
            pos_x_mem[ix] = it.px;
            pos_y_mem[ix] = it.py;
          end
          if (it.op != OP_SET_POS) begin
            vel_x_mem[ix] = it.vx;
            vel_y_mem[ix] = it.vy;
          end
        end
      end
      OP_CARDINAL: begin
        if (n > 1) begin
          k = 65536 - tension_q;
          vel_x_mem[0]   = it.vx;
          vel_y_mem[0]   = it.vy;
          vel_x_mem[n-1] = it.evx;
          vel_y_mem[n-1] = it.evy;
          for (i = 1; i + 1 < n; i++) begin
            dx = longint'(pos_x_mem[i+1]) - longint'(pos_x_mem[i-1]);
            dy = longint'(pos_y_mem[i+1]) - longint'(pos_y_mem[i-1]);
            vel_x_mem[i] = clip_s32((dx * k + 65536) >>> 17);
            vel_y_mem[i] = clip_s32((dy * k + 65536) >>> 17);
          end
        end
      end
      OP_READ: begin
        if (ix >= n) r.err = ERR_RANGE;
        else begin
          r.x  = pos_x_mem[ix];
          r.y  = pos_y_mem[ix];
          r.vx = vel_x_mem[ix];
          r.vy = vel_y_mem[ix];
        end
      end
      OP_EVAL_CUM, OP_EVAL_NORM: begin
        s = longint'(it.pt);
        if (it.op == OP_EVAL_NORM) s = s * ((n > 0) ? n - 1 : 0);
        seg = s >>> 16;
        u   = s & 64'hffff;
        if (n < 2 || seg >= n - 1) r.err = ERR_RANGE;
        else begin
          r.x = hermite_blend(pos_x_mem[seg], vel_x_mem[seg],
                              pos_x_mem[seg+1], vel_x_mem[seg+1], u);
          r.y = hermite_blend(pos_y_mem[seg], vel_y_mem[seg],
                              pos_y_mem[seg+1], vel_y_mem[seg+1], u);
        end
      end
      default: ;
    endcase
    r.total = point_cnt[TOT_W-1:0];
    return r;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t r;
    int      gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {7'b0, it.pt, it.hv, it.evy, it.evx, it.vy, it.vx,
                      it.py, it.px, it.idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = spline_predict(it);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_tension(logic [TEN_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    tension_we_i <= 1'b1;
    tension_i    <= v;
    @(posedge clk_i);
    tension_we_i <= 1'b0;
    tension_q = longint'(signed'(v));
  endtask

  function automatic logic signed [DAT_W-1:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1:       return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    w, n;
    n = point_cnt;
    it.idx = $urandom; it.px = rand_word(); it.py = rand_word();
    it.vx = rand_word(); it.vy = rand_word();
    it.evx = rand_word(); it.evy = rand_word();
    it.hv = $urandom_range(0, 1); it.pt = $urandom;
    w = $urandom_range(0, 99);
    if (n < 2 && w < 60) it.op = OP_APPEND;
    else if (n > 40 && w < 8) it.op = OP_CLEAR;
    else if (w < 18) it.op = OP_APPEND;
    else if (w < 26) it.op = OP_INSERT;
    else if (w < 33) it.op = OP_REMOVE;
    else if (w < 34) it.op = OP_CLEAR;
    else if (w < 39) it.op = OP_SET_POINT;
    else if (w < 44) it.op = OP_SET_POS;
    else if (w < 49) it.op = OP_SET_VEL;
    else if (w < 54) it.op = OP_CARDINAL;
    else if (w < 66) it.op = OP_READ;
    else if (w < 80) it.op = OP_EVAL_CUM;
    else if (w < 96) it.op = OP_EVAL_NORM;
    else it.op = op_e'($urandom_range(11, 15));
    if ($urandom_range(0, 9) != 0) begin
      it.idx = $urandom_range(0, (n > 0) ? n : 0);
      if (it.op != OP_INSERT && n > 0 && it.idx == n) it.idx = n - 1;
      if (it.op == OP_EVAL_CUM && n > 1)
        it.pt = $urandom_range(0, ((n - 1) << 16) - 1);
      if (it.op == OP_EVAL_NORM)
        it.pt = $urandom_range(0, 24'h00ffff);
    end
    return it;
  endfunction

  // fill to capacity, exercise the full cases, then empty again
  task automatic full_table_run();
    item_t   it;
    result_t none;
    while (point_cnt < MAX_POINTS_DEF) begin
      it = rand_item();
      it.op = OP_APPEND;
      send_item(it, 1'b0, none);
    end
    it = rand_item(); it.op = OP_APPEND;   send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_INSERT;   it.idx = 8'd255; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_CARDINAL; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_READ;     it.idx = 8'd255; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_EVAL_NORM; it.pt = 24'h00ffff; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_EVAL_CUM; it.pt = 24'hfeffff; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_EVAL_CUM; it.pt = 24'hff0000; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_REMOVE;   it.idx = 8'd0; send_item(it, 1'b0, none);
    it = rand_item(); it.op = OP_CLEAR;    send_item(it, 1'b0, none);
  endtask

  function automatic row_t mk_row(op_e op, logic [IDX_W-1:0] idx, logic [DAT_W-1:0] p,
                                  logic hv, logic [PT_W-1:0] pt, bit typed,
                                  logic [TOT_W-1:0] total, err_e err);
    row_t r;
    r.it.op = op; r.it.idx = idx; r.it.px = p; r.it.py = ~p;
    r.it.vx = ~p; r.it.vy = p; r.it.evx = p ^ 32'h5a5a5a5a; r.it.evy = ~p ^ 32'h5a5a5a5a;
    r.it.hv = hv; r.it.pt = pt; r.typed = typed;
    r.res.x = '0; r.res.y = '0; r.res.vx = '0; r.res.vy = '0;
    r.res.total = total; r.res.err = err;
    return r;
  endfunction

  // receiver side
  initial begin
    int stall;
    result_t exp_r, got;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (results_seen == 150) stall = 400;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_seen++;
      got.x     = m_axis_tdata[31:0];
      got.y     = m_axis_tdata[63:32];
      got.vx    = m_axis_tdata[95:64];
      got.vy    = m_axis_tdata[127:96];
      got.total = m_axis_tdata[136:128];
      got.err   = err_e'(m_axis_tuser);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result item x=%h err=%0d", got.x, got.err);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.x !== exp_r.x || got.y !== exp_r.y || got.vx !== exp_r.vx ||
            got.vy !== exp_r.vy || got.total !== exp_r.total || got.err !== exp_r.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch item %0d exp x=%h y=%h vx=%h vy=%h n=%0d e=%0d got x=%h y=%h vx=%h vy=%h n=%0d e=%0d",
                     results_seen, exp_r.x, exp_r.y, exp_r.vx, exp_r.vy, exp_r.total,
                     exp_r.err, got.x, got.y, got.vx, got.vy, got.total, got.err);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILURE");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    row_t    rows[$];
    item_t   it;
    result_t none;
    logic [TEN_W-1:0] tensions[5];
    int      ph, j;
    rst_ni = 1'b0; tension_we_i = 1'b0; tension_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = OP_NONE;
    mismatch_cnt = 0; results_seen = 0; idle_cycles = 0;
    point_cnt = 0; tension_q = 0;
    none = '{default: '0, err: ERR_OK};

    rows.push_back(mk_row(OP_READ,      8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd0, ERR_RANGE));
    rows.push_back(mk_row(OP_EVAL_CUM,  8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd0, ERR_RANGE));
    rows.push_back(mk_row(OP_EVAL_NORM, 8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd0, ERR_RANGE));
    rows.push_back(mk_row(OP_CARDINAL,  8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_APPEND,    8'd0,   32'h7fffffff, 1'b1, 24'h0,     1, 9'd1, ERR_OK));
    rows.push_back(mk_row(OP_CARDINAL,  8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd1, ERR_OK));
    rows.push_back(mk_row(OP_INSERT,    8'd2,   32'h1,        1'b0, 24'h0,     1, 9'd1, ERR_RANGE));
    rows.push_back(mk_row(OP_INSERT,    8'd1,   32'h80000000, 1'b0, 24'h0,     1, 9'd2, ERR_OK));
    rows.push_back(mk_row(OP_INSERT,    8'd0,   32'h00018000, 1'b0, 24'h0,     1, 9'd3, ERR_OK));
    rows.push_back(mk_row(OP_APPEND,    8'hff,  32'hfffe0000, 1'b0, 24'h0,     1, 9'd4, ERR_OK));
    rows.push_back(mk_row(OP_SET_POINT, 8'd1,   32'h00050000, 1'b0, 24'h0,     1, 9'd4, ERR_OK));
    rows.push_back(mk_row(OP_SET_POS,   8'd2,   32'h12345678, 1'b0, 24'h0,     1, 9'd4, ERR_OK));
    rows.push_back(mk_row(OP_SET_VEL,   8'd3,   32'hedcba987, 1'b0, 24'h0,     1, 9'd4, ERR_OK));
    rows.push_back(mk_row(OP_SET_POS,   8'd4,   32'h0,        1'b0, 24'h0,     1, 9'd4, ERR_RANGE));
    rows.push_back(mk_row(OP_CARDINAL,  8'd0,   32'h00030000, 1'b0, 24'h0,     0, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_READ,      8'd1,   32'h0,        1'b0, 24'h0,     0, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_READ,      8'd3,   32'h0,        1'b0, 24'h0,     0, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_EVAL_CUM,  8'd0,   32'h0,        1'b0, 24'h02ffff, 0, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_EVAL_CUM,  8'd0,   32'h0,        1'b0, 24'h030000, 1, 9'd4, ERR_RANGE));
    rows.push_back(mk_row(OP_EVAL_NORM, 8'd0,   32'h0,        1'b0, 24'h008000, 0, 9'd0, ERR_OK));
    rows.push_back(mk_row(OP_EVAL_NORM, 8'd0,   32'h0,        1'b0, 24'h010000, 1, 9'd4, ERR_RANGE));
    rows.push_back(mk_row(OP_REMOVE,    8'd1,   32'h0,        1'b0, 24'h0,     1, 9'd3, ERR_OK));
    rows.push_back(mk_row(OP_REMOVE,    8'd3,   32'h0,        1'b0, 24'h0,     1, 9'd3, ERR_RANGE));
    rows.push_back(mk_row(op_e'(4'd11), 8'd0,   32'h0,        1'b0, 24'h0,     1, 9'd3, ERR_OK));
    rows.push_back(mk_row(OP_CLEAR,     8'd0,   32'h0,        1'b0, 24'hffffff, 1, 9'd0, ERR_OK));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_tension(19'h0);
    foreach (rows[r]) send_item(rows[r].it, rows[r].typed, rows[r].res);

    tensions = '{19'h20000, 19'h60000, 19'h7ffff, 19'h0,
                 TEN_W'($urandom_range(0, 262144) - 131072)};
    for (ph = 0; ph < 5; ph++) begin
      write_tension(tensions[ph]);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        it = rand_item();
        send_item(it, 1'b0, none);
      end
      if (ph == 1) full_table_run();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
